/* rtl/pwm_divider_wrap_planner_defines.svh */
// Assertion macros shared by the PWM divider and wrap planner RTL.
`ifndef PWM_DIVIDER_WRAP_PLANNER_DEFINES_SVH
`define PWM_DIVIDER_WRAP_PLANNER_DEFINES_SVH

// Property that must hold at every clock edge out of reset.
`define PDWP_ASSERT_HOLDS(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("pdwp: invariant violated");

// Consequent must hold in the same cycle as the antecedent.
`define PDWP_ASSERT_IMPLIES(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("pdwp: implication violated");

// Consequent must hold in the cycle after the antecedent.
`define PDWP_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("pdwp: next-cycle implication violated");

`endif

/* rtl/pdwp_pkg.sv */
// Shared types and constants of the PWM divider and wrap planner.
`default_nettype none

package pdwp_pkg;

    // Field widths
    localparam int CLK_W   = 28;
    localparam int DIVS_W  = 13;
    localparam int WRAP_W  = 16;
    localparam int LVL_W   = 16;
    localparam int DUTY_W  = 16;
    localparam int DUTYS_W = 14;

    // Shared divider and multiplier widths
    localparam int NUM_W  = 34;
    localparam int DEN_W  = 45;
    localparam int MA_W   = 28;
    localparam int MB_W   = 17;
    localparam int PROD_W = MA_W + MB_W;

    // Stream and register port widths
    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 96;
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;

    localparam logic [DUTYS_W-1:0] DUTY_FULL   = 14'd10000;
    localparam logic [14:0]        DUTY_DEN    = 15'd20000;
    localparam logic [DIVS_W-1:0]  DIV_MIN     = 13'd16;
    localparam logic [CLK_W-1:0]   CLOCK_RESET = 28'd125000000;

    // Register index of the system clock register (paddr bit 2)
    localparam logic REG_CLOCK = 1'b0;

    // Input operations
    localparam logic OP_FREQ = 1'b0;
    localparam logic OP_DUTY = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_LOAD,
        ST_DIV,
        ST_POST,
        ST_DONE
    } state_t;

    typedef enum logic [2:0] {
        K_DIV,
        K_Q,
        K_LVA,
        K_LVB,
        K_DUTY,
        K_ACT
    } step_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    typedef struct packed {
        logic              op;
        logic [CLK_W-1:0]  target_hz;
        logic              channel_sel;
        logic [DUTY_W-1:0] duty_hundredths;
    } req_t;

    typedef struct packed {
        logic [DIVS_W-1:0] divider_sixteenths;
        logic [WRAP_W-1:0] wrap_top;
        logic [LVL_W-1:0]  level_a;
        logic [LVL_W-1:0]  level_b;
        logic [CLK_W-1:0]  actual_hz;
    } result_t;

endpackage

`default_nettype wire

/* rtl/pdwp_divider.sv */
// Bit-serial restoring divider, one quotient bit per cycle.
`default_nettype none
`include "pwm_divider_wrap_planner_defines.svh"

module pdwp_divider import pdwp_pkg::*; #(
    parameter int NUM_W_P = 34,
    parameter int DEN_W_P = 45
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               start,
    input  wire logic [NUM_W_P-1:0] numerator,
    input  wire logic [DEN_W_P-1:0] denominator,
    output logic [NUM_W_P-1:0]      quotient,
    output div_stat_t               stat
);

    localparam int CNT_W = $clog2(NUM_W_P + 1);

    logic [DEN_W_P-1:0] rem_reg, rem_next;
    logic [NUM_W_P-1:0] quo_reg, quo_next;
    logic [DEN_W_P-1:0] den_reg, den_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;

    logic [DEN_W_P:0]   trial;
    logic [DEN_W_P:0]   diff;
    logic               ge;

    // Shift in the next numerator bit and try a subtract
    assign trial = {rem_reg, quo_reg[NUM_W_P-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign ge    = trial >= {1'b0, den_reg};

    always_comb begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (busy_reg) begin
            rem_next = ge ? diff[DEN_W_P-1:0] : trial[DEN_W_P-1:0];
            quo_next = {quo_reg[NUM_W_P-2:0], ge};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end else if (start) begin
            rem_next  = '0;
            quo_next  = numerator;
            den_next  = denominator;
            cnt_next  = CNT_W'(NUM_W_P);
            busy_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath registers need no reset
    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign quotient  = quo_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

    `PDWP_ASSERT_IMPLIES(a_done_not_busy, aclk, aresetn, done_reg, !busy_reg)

endmodule

`default_nettype wire

/* rtl/pdwp_core.sv */
// Sequencer, planner state and shared multiplier around the serial divider.
`default_nettype none
`include "pwm_divider_wrap_planner_defines.svh"

module pdwp_core import pdwp_pkg::*; #(
    parameter int WRAP_MAX    = 65535,
    parameter int DIVIDER_MAX = 256
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             start,
    input  wire req_t             req,
    input  wire logic [CLK_W-1:0] clock_hz,
    input  wire logic             out_free,
    output logic                  idle,
    output logic                  res_valid,
    output result_t               res
);

    localparam logic [NUM_W-1:0]  DMAX_Q = NUM_W'(DIVIDER_MAX * 16);
    localparam logic [DIVS_W-1:0] DMAX_D = DIVS_W'(DIVIDER_MAX * 16);
    localparam logic [NUM_W-1:0]  WMAX_Q = NUM_W'(WRAP_MAX);
    localparam logic [WRAP_W-1:0] WMAX_W = WRAP_W'(WRAP_MAX);

    state_t state_reg, state_next;
    step_t  step_reg, step_next;

    logic [CLK_W-1:0]   f_reg, f_next;
    logic               chan_reg, chan_next;
    logic [DUTYS_W-1:0] duty_reg, duty_next;

    logic [DIVS_W-1:0]  divider_reg, divider_next;
    logic [WRAP_W-1:0]  wrap_reg, wrap_next;
    logic [WRAP_W-1:0]  old_wrap_reg, old_wrap_next;
    logic [LVL_W-1:0]   lvl_a_reg, lvl_a_next;
    logic [LVL_W-1:0]   lvl_b_reg, lvl_b_next;
    logic [CLK_W-1:0]   actual_reg, actual_next;
    logic [PROD_W-1:0]  prod_reg, prod_next;

    logic [MA_W-1:0]    mul_a;
    logic [MB_W-1:0]    mul_b;
    logic [PROD_W-1:0]  mul_p;
    logic [NUM_W-1:0]   clk16;
    logic [NUM_W-1:0]   twice_prod;
    logic [NUM_W-1:0]   div_num;
    logic [DEN_W-1:0]   div_den;
    logic [NUM_W-1:0]   q;
    logic [NUM_W-1:0]   q_m1;
    logic               div_start;
    div_stat_t          div_stat;

    assign clk16      = NUM_W'({clock_hz, 4'b0000});
    assign twice_prod = {prod_reg[NUM_W-2:0], 1'b0};
    assign q_m1       = q - NUM_W'(1);
    assign div_start  = (state_reg == ST_LOAD);

    // Select the operands of the shared multiplier for this step
    always_comb begin
        case (step_reg)
            K_DIV: begin
                mul_a = f_reg;
                mul_b = MB_W'(WRAP_MAX);
            end
            K_Q: begin
                mul_a = f_reg;
                mul_b = MB_W'(divider_reg);
            end
            K_LVA: begin
                mul_a = MA_W'(lvl_a_reg);
                mul_b = MB_W'(wrap_reg);
            end
            K_LVB: begin
                mul_a = MA_W'(lvl_b_reg);
                mul_b = MB_W'(wrap_reg);
            end
            K_DUTY: begin
                mul_a = MA_W'(duty_reg);
                mul_b = MB_W'(wrap_reg);
            end
            K_ACT: begin
                mul_a = MA_W'(divider_reg);
                mul_b = MB_W'(wrap_reg) + MB_W'(1);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // Build the dividend and divisor from the registered product
    always_comb begin
        case (step_reg)
            K_LVA, K_LVB: begin
                div_num = twice_prod + NUM_W'(old_wrap_reg);
                div_den = DEN_W'({old_wrap_reg, 1'b0});
            end
            K_DUTY: begin
                div_num = twice_prod + NUM_W'(DUTY_FULL);
                div_den = DEN_W'(DUTY_DEN);
            end
            default: begin
                div_num = clk16;
                div_den = prod_reg;
            end
        endcase
    end

    pdwp_divider #(
        .NUM_W_P (NUM_W),
        .DEN_W_P (DEN_W)
    ) u_divider (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .start       (div_start),
        .numerator   (div_num),
        .denominator (div_den),
        .quotient    (q),
        .stat        (div_stat)
    );

    // Sequencer: next state and register updates
    always_comb begin
        state_next    = state_reg;
        step_next     = step_reg;
        f_next        = f_reg;
        chan_next     = chan_reg;
        duty_next     = duty_reg;
        divider_next  = divider_reg;
        wrap_next     = wrap_reg;
        old_wrap_next = old_wrap_reg;
        lvl_a_next    = lvl_a_reg;
        lvl_b_next    = lvl_b_reg;
        actual_next   = actual_reg;
        prod_next     = prod_reg;
        res_valid     = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    f_next    = (req.target_hz == '0) ? CLK_W'(1) : req.target_hz;
                    chan_next = req.channel_sel;
                    duty_next = (req.duty_hundredths > DUTY_W'(DUTY_FULL)) ?
                                DUTY_FULL : req.duty_hundredths[DUTYS_W-1:0];
                    step_next  = (req.op == OP_DUTY) ? K_DUTY : K_DIV;
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                prod_next  = mul_p;
                state_next = ST_LOAD;
            end
            ST_LOAD: begin
                state_next = ST_DIV;
            end
            ST_DIV: begin
                if (div_stat.done) begin
                    state_next = ST_POST;
                end
            end
            ST_POST: begin
                state_next = ST_MUL;
                case (step_reg)
                    K_DIV: begin
                        // Clamp the divider to one up to the maximum
                        if (q < NUM_W'(DIV_MIN)) begin
                            divider_next = DIV_MIN;
                        end else if (q > DMAX_Q) begin
                            divider_next = DMAX_D;
                        end else begin
                            divider_next = q[DIVS_W-1:0];
                        end
                        step_next = K_Q;
                    end
                    K_Q: begin
                        // Keep the old wrap for the level rescale
                        old_wrap_next = wrap_reg;
                        if (q < NUM_W'(2)) begin
                            wrap_next = WRAP_W'(1);
                        end else if (q_m1 > WMAX_Q) begin
                            wrap_next = WMAX_W;
                        end else begin
                            wrap_next = q_m1[WRAP_W-1:0];
                        end
                        step_next = K_LVA;
                    end
                    K_LVA: begin
                        lvl_a_next = q[LVL_W-1:0];
                        step_next  = K_LVB;
                    end
                    K_LVB: begin
                        lvl_b_next = q[LVL_W-1:0];
                        step_next  = K_ACT;
                    end
                    K_DUTY: begin
                        if (chan_reg) begin
                            lvl_b_next = q[LVL_W-1:0];
                        end else begin
                            lvl_a_next = q[LVL_W-1:0];
                        end
                        step_next = K_ACT;
                    end
                    K_ACT: begin
                        actual_next = q[CLK_W-1:0];
                        state_next  = ST_DONE;
                    end
                    default: begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_DONE: begin
                // Hold until the output register can take the result
                if (out_free) begin
                    res_valid  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            step_reg    <= K_DIV;
            divider_reg <= DIV_MIN;
            wrap_reg    <= WRAP_W'(65535);
            lvl_a_reg   <= '0;
            lvl_b_reg   <= '0;
        end else begin
            state_reg   <= state_next;
            step_reg    <= step_next;
            divider_reg <= divider_next;
            wrap_reg    <= wrap_next;
            lvl_a_reg   <= lvl_a_next;
            lvl_b_reg   <= lvl_b_next;
        end
    end

    // Per-transaction working registers need no reset
    always_ff @(posedge aclk) begin
        f_reg        <= f_next;
        chan_reg     <= chan_next;
        duty_reg     <= duty_next;
        old_wrap_reg <= old_wrap_next;
        actual_reg   <= actual_next;
        prod_reg     <= prod_next;
    end

    assign idle = (state_reg == ST_IDLE);

    assign res.divider_sixteenths = divider_reg;
    assign res.wrap_top           = wrap_reg;
    assign res.level_a            = lvl_a_reg;
    assign res.level_b            = lvl_b_reg;
    assign res.actual_hz          = actual_reg;

    `PDWP_ASSERT_HOLDS(a_divider_range, aclk, aresetn,
                       (divider_reg >= DIV_MIN) && (divider_reg <= DMAX_D))
    `PDWP_ASSERT_HOLDS(a_wrap_range, aclk, aresetn,
                       (wrap_reg != '0) && (wrap_reg <= WMAX_W))
    `PDWP_ASSERT_NEXT(a_load_starts_div, aclk, aresetn, state_reg == ST_LOAD, div_stat.busy)

endmodule

`default_nettype wire

/* rtl/pwm_divider_wrap_planner.sv */
// Top level of the PWM divider and wrap planner: APB register, stream ports.
//
// Usage:
//   The input stream carries one request per transaction. s_tuser selects the
//   operation: 0 plans a new frequency from target_hz, 1 sets the compare
//   level of one channel from a duty in hundredths of a percent.
//   Every request yields exactly one result transaction on the output stream
//   with the divider (sixteenths), wrap, both compare levels and the
//   frequency that they produce.
//   The user must write system_clock_hz through the APB port at address 0
//   only while idle; the block does not enforce this. pready is always high.
// Sequencing:
//   One shared multiplier feeds one bit-serial divider; each step runs
//   multiply, load, shifts, done and store. A frequency request runs five
//   steps, a duty request two. s_tready is high only while idle, one request
//   in flight.
// Reset and stalls:
//   Reset restores a divider of one, a wrap of 65535, zero levels and a
//   125 MHz clock. A finished result sits in the output register until taken;
//   a new request is accepted meanwhile, and its result waits for the slot.
`default_nettype none

module pwm_divider_wrap_planner import pdwp_pkg::*; #(
    parameter int WRAP_MAX    = 65535,
    parameter int DIVIDER_MAX = 256
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // APB configuration port
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [PADDR_W-1:0]   paddr,
    input  wire logic [PDATA_W-1:0]   pwdata,
    output logic [PDATA_W-1:0]        prdata,
    output logic                      pready,
    // Request stream
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // [27:0] target_hz, [28] channel_sel, [44:29] duty_hundredths
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    // [0] op
    input  wire logic                 s_tuser,
    // Result stream
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // [12:0] divider_sixteenths, [28:13] wrap_top, [44:29] level_a,
    // [60:45] level_b, [88:61] actual_hz
    output logic [M_TDATA_W-1:0]      m_tdata
);

    logic [CLK_W-1:0]     clock_reg, clock_next;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    logic    cfg_write;
    logic    start;
    logic    idle;
    logic    out_free;
    logic    res_valid;
    req_t    req;
    result_t res;

    // Register write and read-back
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign clock_next = (cfg_write && (paddr[2] == REG_CLOCK)) ?
                        pwdata[CLK_W-1:0] : clock_reg;
    assign prdata    = (paddr[2] == REG_CLOCK) ?
                       PDATA_W'(clock_reg) : PDATA_W'(paddr[1:0] & 2'b00);

    // Unpack the request transaction
    assign req.op              = s_tuser;
    assign req.target_hz       = s_tdata[27:0];
    assign req.channel_sel     = s_tdata[28];
    assign req.duty_hundredths = s_tdata[44:29];

    assign s_tready = idle;
    assign start    = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    pdwp_core #(
        .WRAP_MAX    (WRAP_MAX),
        .DIVIDER_MAX (DIVIDER_MAX)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (start),
        .req       (req),
        .clock_hz  (clock_reg),
        .out_free  (out_free),
        .idle      (idle),
        .res_valid (res_valid),
        .res       (res)
    );

    // Load the output register, drop valid once the transaction is taken
    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (res_valid) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = M_TDATA_W'({res.actual_hz, res.level_b, res.level_a,
                                        res.wrap_top, res.divider_sixteenths});
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clock_reg    <= CLOCK_RESET;
            m_tvalid_reg <= 1'b0;
        end else begin
            clock_reg    <= clock_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire

/* sim/pwm_plan_checker.sv */
// Checker for the PWM divider and wrap planner: predicts every plan and compares results.
`timescale 1ns / 1ps

module pwm_plan_checker import pdwp_pkg::*; #(
    parameter int WRAP_MAX    = 65535,
    parameter int DIVIDER_MAX = 256
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // APB configuration port
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [PADDR_W-1:0]   paddr,
    input  logic [PDATA_W-1:0]   pwdata,
    input  logic [PDATA_W-1:0]   prdata,
    input  logic                 pready,
    // Request stream
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    // [27:0] target_hz, [28] channel_sel, [44:29] duty_hundredths
    input  logic [S_TDATA_W-1:0] s_tdata,
    // [0] op
    input  logic                 s_tuser,
    // Result stream
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    // [12:0] divider_sixteenths, [28:13] wrap_top, [44:29] level_a,
    // [60:45] level_b, [88:61] actual_hz
    input  logic [M_TDATA_W-1:0] m_tdata,
    output int                   fail_count,
    output int                   plans_pending
);

    // Own copy of the register and of the planner state
    logic [CLK_W-1:0]  clock_hz;
    logic [DIVS_W-1:0] divider_now;
    logic [WRAP_W-1:0] wrap_now;
    logic [LVL_W-1:0]  levels [2];

    result_t planned_results [$];
    int      errors;

    // Divide rounding to nearest, ties up
    function automatic logic [63:0] div_nearest(input logic [63:0] num,
                                                input logic [63:0] den);
        return (64'd2 * num + den) / (64'd2 * den);
    endfunction

    // Apply one request to the state and return the settings now in use
    function automatic result_t plan_request(input req_t rq);
        logic [63:0] f;
        logic [63:0] clk16;
        logic [63:0] div;
        logic [63:0] q;
        logic [63:0] wrap;
        logic [63:0] old_wrap;
        logic [63:0] duty;
        logic [63:0] den;
        result_t     r;
        clk16 = 64'(clock_hz) << 4;
        if (rq.op == OP_FREQ) begin
            f   = (rq.target_hz == '0) ? 64'd1 : 64'(rq.target_hz);
            div = clk16 / (f * 64'(WRAP_MAX));
            if (div < 64'(DIV_MIN))
                div = 64'(DIV_MIN);
            if (div > 64'(DIVIDER_MAX) * 64'd16)
                div = 64'(DIVIDER_MAX) * 64'd16;
            q    = clk16 / (div * f);
            wrap = (q < 64'd2) ? 64'd1 : q - 64'd1;
            if (wrap > 64'(WRAP_MAX))
                wrap = 64'(WRAP_MAX);
            // rescale against the wrap in use before this request
            old_wrap = (wrap_now == '0) ? 64'd1 : 64'(wrap_now);
            for (int i = 0; i < 2; i++)
                levels[i] = LVL_W'(div_nearest(64'(levels[i]) * wrap, old_wrap));
            divider_now = DIVS_W'(div);
            wrap_now    = WRAP_W'(wrap);
        end else begin
            duty = (64'(rq.duty_hundredths) > 64'(DUTY_FULL)) ?
                   64'(DUTY_FULL) : 64'(rq.duty_hundredths);
            levels[rq.channel_sel] = LVL_W'(div_nearest(64'(wrap_now) * duty,
                                                        64'(DUTY_FULL)));
        end
        den = 64'(divider_now) * (64'(wrap_now) + 64'd1);
        r.divider_sixteenths = divider_now;
        r.wrap_top           = wrap_now;
        r.level_a            = levels[0];
        r.level_b            = levels[1];
        r.actual_hz          = (den == 64'd0) ? '0 : CLK_W'(clk16 / den);
        return r;
    endfunction

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    always @(posedge aclk) begin
        result_t want;
        result_t got;
        req_t    rq;
        if (!aresetn) begin
            clock_hz    = CLOCK_RESET;
            divider_now = DIV_MIN;
            wrap_now    = 16'hFFFF;
            levels[0]   = '0;
            levels[1]   = '0;
            errors      = 0;
            planned_results.delete();
        end else begin
            // Track register writes, check register reads
            if (psel && penable && pready && paddr[2] == REG_CLOCK) begin
                if (pwrite)
                    clock_hz = CLK_W'(pwdata);
                else if (prdata !== PDATA_W'(clock_hz)) begin
                    $error("system_clock_hz: expected %0d, got %0d", clock_hz, prdata);
                    errors++;
                end
            end
            // Retire the oldest plan before queueing a new one
            if (m_tvalid && m_tready) begin
                got.divider_sixteenths = m_tdata[12:0];
                got.wrap_top           = m_tdata[28:13];
                got.level_a            = m_tdata[44:29];
                got.level_b            = m_tdata[60:45];
                got.actual_hz          = m_tdata[88:61];
                if (planned_results.size() == 0) begin
                    $error("result transaction with no request outstanding: wrap %0d",
                           got.wrap_top);
                    errors++;
                end else begin
                    want = planned_results.pop_front();
                    check_field("divider_sixteenths", 64'(want.divider_sixteenths),
                                64'(got.divider_sixteenths));
                    check_field("wrap_top", 64'(want.wrap_top), 64'(got.wrap_top));
                    check_field("level_a", 64'(want.level_a), 64'(got.level_a));
                    check_field("level_b", 64'(want.level_b), 64'(got.level_b));
                    check_field("actual_hz", 64'(want.actual_hz), 64'(got.actual_hz));
                end
            end
            if (s_tvalid && s_tready) begin
                rq.op              = s_tuser;
                rq.target_hz       = s_tdata[27:0];
                rq.channel_sel     = s_tdata[28];
                rq.duty_hundredths = s_tdata[44:29];
                planned_results.push_back(plan_request(rq));
            end
        end
        fail_count    <= errors;
        plans_pending <= planned_results.size();
    end

endmodule

/* sim/tb_top.sv */
// Top of the PWM divider and wrap planner testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_top;
    import pdwp_pkg::*;

    localparam int WRAP_MAX       = 65535;
    localparam int DIVIDER_MAX    = 256;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int LONG_HOLD      = 1500;
    localparam int SETTLE_CYCLES  = 250;

    logic                 aclk;
    logic                 aresetn;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [PADDR_W-1:0]   paddr;
    logic [PDATA_W-1:0]   pwdata;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;
    logic                 s_tvalid;
    logic                 s_tready;
    // [27:0] target_hz, [28] channel_sel, [44:29] duty_hundredths
    logic [S_TDATA_W-1:0] s_tdata;
    // [0] op
    logic                 s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    // [12:0] divider_sixteenths, [28:13] wrap_top, [44:29] level_a,
    // [60:45] level_b, [88:61] actual_hz
    logic [M_TDATA_W-1:0] m_tdata;

    int   fail_count;
    int   plans_pending;
    int   send_idle_pct = 26;
    int   recv_idle_pct = 60;
    logic hold_req      = 1'b0;
    logic hold_done     = 1'b0;
    int   freq_sent     = 0;
    int   duty_sent     = 0;

    pwm_divider_wrap_planner #(
        .WRAP_MAX    (WRAP_MAX),
        .DIVIDER_MAX (DIVIDER_MAX)
    ) u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    pwm_plan_checker #(
        .WRAP_MAX    (WRAP_MAX),
        .DIVIDER_MAX (DIVIDER_MAX)
    ) u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .fail_count    (fail_count),
        .plans_pending (plans_pending)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Result side: random stalls, plus one long hold-off to back the block up
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req && !hold_done) begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD - 1) @(negedge aclk);
                hold_done = 1'b1;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // End the run if no transaction moves for too long
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
                (psel && penable && pready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Test completed with failures");
        $finish;
    end

    // One APB transfer to the clock register; called and returns at a falling edge
    task automatic apb_access(input logic wr, input logic [PDATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {REG_CLOCK, 2'b00};
        pwdata  <= data;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge aclk);
    endtask

    // Offer one request, with random idle cycles ahead of it, until it is taken
    task automatic send_req(input logic op, input logic [CLK_W-1:0] target,
                            input logic ch, input logic [DUTY_W-1:0] duty);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {3'b000, duty, ch, target};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (op == OP_FREQ)
            freq_sent++;
        else
            duty_sent++;
    endtask

    // Stop offering and wait until every plan has come back
    task automatic drain_plans();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (plans_pending != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    initial begin
        logic [CLK_W-1:0]  seg_clk [8];
        logic [CLK_W-1:0]  target;
        logic [DUTY_W-1:0] duty;
        logic              op;
        int                n;
        int                k;

        aresetn  = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = OP_FREQ;

        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        // read back the reset clock
        apb_access(1'b0, '0);

        // Directed: saturation, clamps, wrap edges and ignored fields
        send_req(OP_DUTY, '0, 1'b0, 16'd10000);
        send_req(OP_DUTY, '0, 1'b1, 16'd5000);
        send_req(OP_FREQ, '0, 1'b0, '0);
        send_req(OP_FREQ, 28'd1000, 1'b0, '0);
        send_req(OP_FREQ, 28'd200000000, 1'b0, '0);
        send_req(OP_FREQ, '1, 1'b0, '0);
        send_req(OP_FREQ, 28'd125000000, 1'b0, '0);
        send_req(OP_FREQ, 28'd62500000, 1'b0, '0);
        send_req(OP_FREQ, 28'd41666666, 1'b0, '0);
        send_req(OP_DUTY, '0, 1'b0, '1);
        send_req(OP_DUTY, '0, 1'b1, '0);
        send_req(OP_DUTY, '0, 1'b0, 16'd10001);
        send_req(OP_DUTY, '0, 1'b1, 16'd1);
        send_req(OP_FREQ, 28'd1907, 1'b0, '0);
        send_req(OP_FREQ, 28'd1908, 1'b0, '0);
        send_req(OP_DUTY, '0, 1'b0, 16'd3333);
        send_req(OP_DUTY, '0, 1'b1, 16'd6667);
        send_req(OP_FREQ, 28'd7, 1'b0, '0);
        send_req(OP_FREQ, 28'd29, 1'b0, '0);
        send_req(OP_DUTY, '1, 1'b1, 16'd2500);
        send_req(OP_FREQ, 28'd20000, 1'b1, '1);
        send_req(OP_FREQ, 28'd19999, 1'b0, '0);
        send_req(OP_DUTY, '0, 1'b0, 16'd7500);

        seg_clk = '{28'd200000000, 28'd1, '1, '0, 28'd16000000, CLK_W'($urandom),
                    28'd48000000, CLK_W'($urandom_range(200000000, 1000000))};

        // Random phases, each under its own clock setting
        for (int s = 0; s < 8; s++) begin
            drain_plans();
            apb_access(1'b1, PDATA_W'(seg_clk[s]));
            apb_access(1'b0, '0);
            if (s < 3) begin
                send_idle_pct = 26;
                recv_idle_pct = 60;
            end else if (s < 6) begin
                send_idle_pct = 60;
                recv_idle_pct = 26;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if (s == 6)
                hold_req = 1'b1;
            n = (seg_clk[s] < 2) ? 30 : 110;
            for (int i = 0; i < n; i++) begin
                op = $urandom_range(1) ? OP_DUTY : OP_FREQ;
                // spread targets over every magnitude, with clamps and clock edges
                case ($urandom_range(15))
                    0: target = '0;
                    1: target = CLK_W'($urandom);
                    2: target = seg_clk[s] >> $urandom_range(3, 0);
                    default: begin
                        k = $urandom_range(CLK_W, 1);
                        target = CLK_W'($urandom) >> (CLK_W - k);
                    end
                endcase
                case ($urandom_range(9))
                    0: duty = DUTY_W'($urandom);
                    1: duty = $urandom_range(1) ? '1 : '0;
                    2: duty = DUTY_W'($urandom_range(10001, 9999));
                    default: duty = DUTY_W'($urandom_range(10000));
                endcase
                send_req(op, target, 1'($urandom_range(1)), duty);
            end
        end

        drain_plans();
        repeat (SETTLE_CYCLES) @(negedge aclk);

        $display("Covered %0d frequency and %0d duty requests under nine clock settings,",
                 freq_sent, duty_sent);
        $display("from zero to full scale, with idling on both sides and a long output stall.");
        if (fail_count == 0 && plans_pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

/* pwm_divider_wrap_planner.f */
+incdir+rtl
rtl/pdwp_pkg.sv
rtl/pdwp_divider.sv
rtl/pdwp_core.sv
rtl/pwm_divider_wrap_planner.sv
sim/pwm_plan_checker.sv
sim/tb_top.sv
